>>> rtl/fcms_pkg.sv
package fcms_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 31;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KEY_LIMIT     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TARGET_COLUMN = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SEPARATOR     = 2'd2;

   // Register reset values
   localparam logic [30:0] KEY_LIMIT_RESET     = 31'd2000000;
   localparam logic [4:0]  TARGET_COLUMN_RESET = 5'd5;
   localparam logic [7:0]  SEPARATOR_RESET     = 8'd124;

   localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
   localparam logic [4:0]  FIELD_MAX = 5'd31;

   // Byte codes
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_VTAB    = 8'd11;
   localparam logic [7:0] CHAR_FEED    = 8'd12;
   localparam logic [7:0] CHAR_CR      = 8'd13;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_PLUS    = 8'd43;
   localparam logic [7:0] CHAR_MINUS   = 8'd45;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_NINE    = 8'd57;

   typedef struct packed {
      logic [30:0] key_limit;
      logic [4:0]  target_column;
      logic [7:0]  separator;
   } cfg_type;

endpackage

>>> rtl/filtered_column_min_scan.sv
// Delimited-text column minimum.
//
// Requests on req_ carry one byte of table text each (req_text_byte) with
// req_final_byte marking the last byte of a table. Byte 10 ends a row and
// csr separator splits fields. Field 1 is the key; a row passes when the key
// is below key_limit, and the minimum of column target_column over passing
// rows comes back on rsp_min_value once per table, after the final byte.
// Non-final requests produce no response.
//
// Throughput: one request per clock unless a final byte is held. Each byte
// goes through an input register, the parse logic (digit shift-add, negate,
// compare) and, for a final byte, a response register, which holds the
// response after the final byte has left the input register.
// A stalled response only holds back a final byte sitting in the input
// register; ordinary bytes keep flowing through the parser meanwhile.
// Reset (synchronous) empties both registers, restores csr defaults
// (2000000, column 5, '|') and starts a fresh table. csr writes are taken
// at once and must only occur while the block is idle.
module filtered_column_min_scan (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [7:0]                             req_text_byte,
   input  logic                                   req_final_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [31:0]                     rsp_min_value,
   input  logic                                   csr_write_enable,
   input  logic [fcms_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [fcms_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   fcms_pkg::cfg_type cfg_ff;

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_final_ff;
   logic        in_fire;

   // response register
   logic               out_valid_ff, out_valid_in;
   logic signed [31:0] out_value_ff;

   logic               result_valid;
   logic signed [31:0] result_value;

   // csr writes; unknown index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_limit     <= fcms_pkg::KEY_LIMIT_RESET;
         cfg_ff.target_column <= fcms_pkg::TARGET_COLUMN_RESET;
         cfg_ff.separator     <= fcms_pkg::SEPARATOR_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            fcms_pkg::REG_KEY_LIMIT:     cfg_ff.key_limit     <= csr_write_data;
            fcms_pkg::REG_TARGET_COLUMN: cfg_ff.target_column <= csr_write_data[4:0];
            fcms_pkg::REG_SEPARATOR:     cfg_ff.separator     <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // A byte leaves the input register unless it is a final byte and the
   // response register is occupied and rsp_ready is low.
   assign in_fire   = in_valid_ff && (!in_final_ff || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || in_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_text_byte;
         in_final_ff <= req_final_byte;
      end
   end

   fcms_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .step         (in_fire),
      .text_byte    (in_byte_ff),
      .final_byte   (in_final_ff),
      .result_valid (result_valid),
      .result_value (result_value)
   );

   always_comb begin
      if (result_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_valid) begin
         out_value_ff <= result_value;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_min_value = out_value_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !result_valid)
      else $error("pending response overwritten");

   a_final_gives_response: assert property (@(posedge clock) disable iff (reset)
      in_fire && in_final_ff |=> out_valid_ff)
      else $error("final byte produced no response");

   a_stall_only_on_final: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_fire |-> in_final_ff && out_valid_ff)
      else $error("input register stalled without cause");

endmodule

>>> rtl/fcms_parser.sv
module fcms_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  fcms_pkg::cfg_type     cfg,
   input  logic                  step,
   input  logic [7:0]            text_byte,
   input  logic                  final_byte,
   output logic                  result_valid,
   output logic signed [31:0]    result_value
);

   typedef enum logic [1:0] {
      PH_AWAIT,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [4:0]  field_index;
      logic [31:0] key_accum;
      logic [31:0] cell_accum;
      phase_type   phase;
      logic        negative;
      logic        row_skipped;
   } pstate_type;

   localparam pstate_type ROW_CLEAR = '{
      field_index: 5'd1,
      key_accum:   32'd0,
      cell_accum:  32'd0,
      phase:       PH_AWAIT,
      negative:    1'b0,
      row_skipped: 1'b0
   };

   pstate_type  state_ff, state_in;
   logic [31:0] running_min_ff, running_min_in;
   logic [4:0]  target;

   // Ends the number in progress; a key that ends also decides the row filter
   function automatic pstate_type finish_number(pstate_type s, logic [4:0] t,
                                                logic [30:0] lim);
      pstate_type  r;
      logic [31:0] v;
      r = s;
      v = 32'd0;
      if (s.phase != PH_DONE) begin
         r.phase = PH_DONE;
         if (s.field_index == 5'd1) begin
            v = s.negative ? (32'd0 - s.key_accum) : s.key_accum;
            r.key_accum = v;
            r.row_skipped = !($signed(v) < $signed({1'b0, lim}));
         end else if (s.field_index == t) begin
            r.cell_accum = s.negative ? (32'd0 - s.cell_accum) : s.cell_accum;
         end
      end
      return r;
   endfunction

   function automatic pstate_type parse_byte(pstate_type s, logic [7:0] b,
                                             logic [4:0] t, logic [30:0] lim);
      pstate_type  r;
      logic        use_key;
      logic        use_cell;
      logic [31:0] acc;
      logic [35:0] prod;
      logic [35:0] cap;
      logic [31:0] sat;
      r = s;
      use_key  = (s.field_index == 5'd1);
      use_cell = !use_key && (s.field_index == t);
      acc  = use_key ? s.key_accum : s.cell_accum;
      // acc * 10 + digit as two shifts and two adds
      prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, b[3:0]};
      cap  = s.negative ? 36'd2147483648 : 36'd2147483647;
      sat  = (prod > cap) ? cap[31:0] : prod[31:0];
      if (s.phase == PH_DONE || (!use_key && !use_cell)) begin
         r.phase = PH_DONE;
      end else if (s.phase == PH_AWAIT && (b inside {fcms_pkg::CHAR_SPACE,
               fcms_pkg::CHAR_TAB, fcms_pkg::CHAR_VTAB, fcms_pkg::CHAR_FEED,
               fcms_pkg::CHAR_CR})) begin
         r = s;   // leading blank
      end else if (s.phase == PH_AWAIT && (b == fcms_pkg::CHAR_PLUS ||
                                           b == fcms_pkg::CHAR_MINUS)) begin
         r.negative = (b == fcms_pkg::CHAR_MINUS);
         r.phase    = PH_DIGITS;
      end else if (b inside {[fcms_pkg::CHAR_ZERO:fcms_pkg::CHAR_NINE]}) begin
         if (use_key) begin
            r.key_accum = sat;
         end else begin
            r.cell_accum = sat;
         end
         r.phase = PH_DIGITS;
      end else begin
         r = finish_number(s, t, lim);
      end
      return r;
   endfunction

   assign target = (cfg.target_column == 5'd0) ? 5'd1 : cfg.target_column;

   always_comb begin : next_state
      pstate_type  s;
      logic [31:0] rmin;
      logic [31:0] cand;
      logic        has;
      logic        opened;
      s      = state_ff;
      rmin   = running_min_ff;
      cand   = 32'd0;
      has    = 1'b0;
      opened = 1'b0;

      if (text_byte == fcms_pkg::CHAR_NEWLINE || final_byte) begin
         // a final byte that is not a newline still gets its own effect first
         if (text_byte != fcms_pkg::CHAR_NEWLINE) begin
            if (text_byte == cfg.separator) begin
               s = finish_number(s, target, cfg.key_limit);
               if (s.field_index < fcms_pkg::FIELD_MAX) begin
                  s.field_index = s.field_index + 5'd1;
                  if (s.field_index == target) begin
                     s.cell_accum = 32'd0;
                     s.negative   = 1'b0;
                     s.phase      = PH_AWAIT;
                     opened       = 1'b1;
                  end
               end
            end else begin
               s = parse_byte(s, text_byte, target, cfg.key_limit);
            end
         end
         // end of row
         s = finish_number(s, target, cfg.key_limit);
         if (target == 5'd1) begin
            has  = 1'b1;
            cand = s.key_accum;
         end else if (s.field_index >= target && !opened) begin
            has  = 1'b1;
            cand = s.cell_accum;
         end
         if (has && !s.row_skipped && ($signed(cand) < $signed(rmin))) begin
            rmin = cand;
         end
         s = ROW_CLEAR;
      end else if (text_byte == cfg.separator) begin
         s = finish_number(s, target, cfg.key_limit);
         if (s.field_index < fcms_pkg::FIELD_MAX) begin
            s.field_index = s.field_index + 5'd1;
            if (s.field_index == target) begin
               s.cell_accum = 32'd0;
               s.negative   = 1'b0;
               s.phase      = PH_AWAIT;
            end
         end
      end else begin
         s = parse_byte(s, text_byte, target, cfg.key_limit);
      end

      result_value = $signed(rmin);
      if (final_byte) begin
         rmin = fcms_pkg::INT32_MAX;
      end
      state_in       = s;
      running_min_in = rmin;
   end

   assign result_valid = step && final_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ROW_CLEAR;
         running_min_ff <= fcms_pkg::INT32_MAX;
      end else if (step) begin
         state_ff       <= state_in;
         running_min_ff <= running_min_in;
      end
   end

   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      step && final_byte |=> state_ff.field_index == 5'd1 &&
                             running_min_ff == fcms_pkg::INT32_MAX)
      else $error("table state not restarted after final byte");

   a_newline_clears_row: assert property (@(posedge clock) disable iff (reset)
      step && text_byte == fcms_pkg::CHAR_NEWLINE |=>
         state_ff.field_index == 5'd1 && state_ff.phase == PH_AWAIT)
      else $error("row state not cleared at newline");

   a_field_index_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff.field_index != 5'd0)
      else $error("field index left its range");

endmodule
